>>> rtl/tsc_pkg.sv
// Shared widths, constants and types of the Taylor-series sine/cosine pipeline.
package tsc_pkg;

    localparam int TERMS_DEF = 8;

    localparam int ANGLE_W = 32;   // Q4.28 input angle
    localparam int VALUE_W = 32;   // Q2.30 result
    localparam int Q_FRAC  = 30;   // fraction bits of the series datapath
    localparam int V_W     = 62;   // signed Q.56 reduction word
    localparam int X_W     = 31;   // reference angle, Q.30, non-negative
    localparam int X2_W    = 32;   // squared reference angle, Q.30
    localparam int H_W     = 32;   // signed Horner accumulator, Q.30
    localparam int T_W     = 32;   // scaled dividend of one Horner step
    localparam int D_W     = 9;    // series denominator, up to 12 terms
    localparam int M_W     = 32;   // reciprocal of the denominator, Q.32

    localparam logic FUNC_SIN = 1'b0;
    localparam logic FUNC_COS = 1'b1;

    localparam logic signed [V_W-1:0] TWO_PI_Q56        = 62'sh6487ED5110B4612;
    localparam logic signed [V_W-1:0] FOUR_PI_Q56       = 62'shC90FDAA22168C24;
    localparam logic signed [V_W-1:0] PI_Q56            = 62'sh3243F6A8885A309;
    localparam logic signed [V_W-1:0] HALF_PI_Q56       = 62'sh1921FB54442D184;
    localparam logic signed [V_W-1:0] THREE_HALF_PI_Q56 = 62'sh4B65F1FCCC8748D;
    localparam logic signed [V_W-1:0] X_RND_Q56         = 62'sd33554432;

    localparam logic signed [H_W-1:0] Q30_ONE = 32'sd1073741824;

    typedef enum logic [1:0] {
        QUAD_1 = 2'd0,
        QUAD_2 = 2'd1,
        QUAD_3 = 2'd2,
        QUAD_4 = 2'd3
    } quad_t;

    typedef struct packed {
        logic              func;
        quad_t             quad;
        logic [X_W-1:0]    x;
        logic [X2_W-1:0]   x2;
    } tsc_ctx_t;

    typedef struct packed {
        logic [D_W-1:0] d_sin;
        logic [D_W-1:0] d_cos;
        logic [M_W-1:0] m_sin;
        logic [M_W-1:0] m_cos;
    } tsc_coef_t;

endpackage

>>> rtl/tsc_horner_step.sv
// One Horner step h' = 1 - round(x2 * h / d), five register stages.
module tsc_horner_step
    import tsc_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  en,
    input  tsc_coef_t             coef,
    input  logic                  in_valid,
    input  tsc_ctx_t              in_ctx,
    input  logic signed [H_W-1:0] in_h,
    output logic                  out_valid,
    output tsc_ctx_t              out_ctx,
    output logic signed [H_W-1:0] out_h
);

    localparam int P_W  = X2_W + H_W - 1;
    localparam int S_W  = P_W - Q_FRAC + 2;
    localparam int PR_W = T_W + M_W;
    localparam int QD_W = T_W + D_W;
    localparam logic signed [H_W-1:0] H_LSB = H_W'(1);

    logic [4:0]            vld_reg;
    tsc_ctx_t              ctx_reg [0:4];
    logic [P_W-1:0]        p_reg, p_next;
    logic [S_W-1:0]        t_sum;
    logic [T_W-1:0]        ta_reg, tb_reg, tc_reg, t_next;
    logic [PR_W-1:0]       prod_reg, prod_next;
    logic [T_W-1:0]        q0;
    logic [QD_W-1:0]       qd_reg, qd_next;
    logic signed [H_W-1:0] base_reg, base_next;
    logic signed [H_W-1:0] h_reg, h_next;
    logic [T_W-1:0]        rem;
    logic [D_W-1:0]        d_a, d_c, d_d;
    logic [M_W-1:0]        m_b;

    assign d_a = (ctx_reg[0].func == FUNC_COS) ? coef.d_cos : coef.d_sin;
    assign m_b = (ctx_reg[1].func == FUNC_COS) ? coef.m_cos : coef.m_sin;
    assign d_c = (ctx_reg[2].func == FUNC_COS) ? coef.d_cos : coef.d_sin;
    assign d_d = (ctx_reg[3].func == FUNC_COS) ? coef.d_cos : coef.d_sin;

    // h entering a step is never negative
    assign p_next = P_W'(in_ctx.x2) * P_W'(in_h[H_W-2:0]);

    // t = floor((p + d * 2^29) / 2^30); quotient is then floor(t / d)
    assign t_sum  = S_W'(p_reg[P_W-1:Q_FRAC-1]) + S_W'(d_a);
    assign t_next = t_sum[T_W:1];

    assign prod_next = PR_W'(ta_reg) * PR_W'(m_b);

    // reciprocal estimate is the quotient or one below it
    assign q0        = prod_reg[PR_W-1:M_W];
    assign qd_next   = QD_W'(q0) * QD_W'(d_c);
    assign base_next = Q30_ONE - $signed(q0);

    assign rem    = tc_reg - qd_reg[T_W-1:0];
    assign h_next = (rem >= T_W'(d_d)) ? base_reg - H_LSB : base_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[3:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ctx_reg[0] <= in_ctx;
            ctx_reg[1] <= ctx_reg[0];
            ctx_reg[2] <= ctx_reg[1];
            ctx_reg[3] <= ctx_reg[2];
            ctx_reg[4] <= ctx_reg[3];
            p_reg      <= p_next;
            ta_reg     <= t_next;
            tb_reg     <= ta_reg;
            tc_reg     <= tb_reg;
            prod_reg   <= prod_next;
            qd_reg     <= qd_next;
            base_reg   <= base_next;
            h_reg      <= h_next;
        end
    end

    assign out_valid = vld_reg[4];
    assign out_ctx   = ctx_reg[4];
    assign out_h     = h_reg;

endmodule

>>> rtl/taylor_sine_cosine.sv
// Top level: pipelined Taylor-series sine/cosine of a Q4.28 angle.
//
//   channel | ports                          | word
//   --------+--------------------------------+------------------------------
//   in      | s_valid s_ready s_func s_angle | func 0 sine / 1 cosine, Q4.28
//   out     | m_valid m_ready m_value        | Q2.30, clamped to +/-1
//
// Six reduction/fold/square stages, five per Horner step (multiply, round,
// reciprocal multiply, back-multiply, correct) for TERMS-1 steps, two
// finishing stages, output reg. One word per cycle sustained. Reset clears
// valid bits and the output buffer. A two-word output buffer absorbs m_ready
// stalls; s_ready falls only when both entries are held, and then the whole
// pipeline holds.
module taylor_sine_cosine
    import tsc_pkg::*;
#(
    parameter int TERMS = TERMS_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic                      s_func,
    input  logic signed [ANGLE_W-1:0] s_angle,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic signed [VALUE_W-1:0] m_value
);

    localparam int SHIFT_X = 56 - Q_FRAC;
    localparam int SQ_W    = 2 * X_W;
    localparam int FP_W    = X_W + H_W - 1;
    localparam int MAG_W   = VALUE_W + 1;

    localparam logic signed [V_W-1:0] PI_RND     = PI_Q56 + X_RND_Q56;
    localparam logic signed [V_W-1:0] RND_M_PI   = X_RND_Q56 - PI_Q56;
    localparam logic signed [V_W-1:0] TWO_PI_RND = TWO_PI_Q56 + X_RND_Q56;

    localparam logic [SQ_W:0] SQ_RND = (SQ_W + 1)'(1) << (Q_FRAC - 1);
    localparam logic [FP_W:0] FP_RND = (FP_W + 1)'(1) << (Q_FRAC - 1);

    localparam logic signed [MAG_W-1:0] ONE_MAG     = MAG_W'(Q30_ONE);
    localparam logic signed [MAG_W-1:0] NEG_ONE_MAG = -ONE_MAG;

    logic en;

    // reduction and fold
    logic                  a1_valid_reg, a2_valid_reg, a3_valid_reg;
    logic                  a4_valid_reg, a5_valid_reg, head_valid_reg;
    logic                  a1_func_reg, a2_func_reg, a3_func_reg, a4_func_reg, a5_func_reg;
    logic signed [V_W-1:0] v_next, a1_v_reg;
    logic signed [V_W-1:0] off_next, a1_off_reg;
    logic signed [V_W-1:0] r_next, a2_r_reg, a3_r_reg;
    quad_t                 quad_next, a3_quad_reg, a4_quad_reg, a5_quad_reg;
    logic signed [V_W-1:0] ref_sum;
    logic [X_W-1:0]        x_next, a4_x_reg, a5_x_reg;
    logic [SQ_W-1:0]       sq_next, a5_sq_reg;
    logic [SQ_W:0]         sq_sum;
    tsc_ctx_t              head_ctx_next, head_ctx_reg;

    // Horner chain
    logic                  st_valid [0:TERMS-1];
    tsc_ctx_t              st_ctx   [0:TERMS-1];
    logic signed [H_W-1:0] st_h     [0:TERMS-1];

    // finish
    logic                    fin1_valid_reg, fin2_valid_reg;
    tsc_ctx_t                fin1_ctx_reg;
    logic signed [H_W-1:0]   fin1_h_reg;
    logic [FP_W-1:0]         fin1_prod_next, fin1_prod_reg;
    logic [FP_W:0]           fp_sum;
    logic signed [MAG_W-1:0] mag_next, fin2_mag_reg;
    logic                    neg_next, fin2_neg_reg;
    logic signed [MAG_W-1:0] clamp_mag, signed_mag;
    logic signed [VALUE_W-1:0] res_value;

    // output buffer
    logic                      out_valid_reg, out_valid_next;
    logic                      skid_valid_reg, skid_valid_next;
    logic signed [VALUE_W-1:0] out_value_reg, out_value_next;
    logic signed [VALUE_W-1:0] skid_value_reg, skid_value_next;
    logic                      out_take;

    assign en      = !skid_valid_reg;
    assign s_ready = en;

    // ---- reduction to [0, 2pi) ----
    assign v_next = {{(V_W - ANGLE_W - 28){s_angle[ANGLE_W-1]}}, s_angle, 28'd0};

    always_comb begin
        priority if (v_next < -TWO_PI_Q56) begin
            off_next = FOUR_PI_Q56;
        end else if (v_next[V_W-1]) begin
            off_next = TWO_PI_Q56;
        end else if (v_next >= TWO_PI_Q56) begin
            off_next = -TWO_PI_Q56;
        end else begin
            off_next = '0;
        end
    end

    assign r_next = a1_v_reg + a1_off_reg;

    // ---- quadrant ----
    always_comb begin
        priority if (a2_r_reg <= HALF_PI_Q56) begin
            quad_next = QUAD_1;
        end else if (a2_r_reg <= PI_Q56) begin
            quad_next = QUAD_2;
        end else if (a2_r_reg <= THREE_HALF_PI_Q56) begin
            quad_next = QUAD_3;
        end else begin
            quad_next = QUAD_4;
        end
    end

    // reference angle plus rounding half, then to Q.30
    always_comb begin
        unique case (a3_quad_reg)
            QUAD_1: ref_sum = a3_r_reg + X_RND_Q56;
            QUAD_2: ref_sum = PI_RND - a3_r_reg;
            QUAD_3: ref_sum = a3_r_reg + RND_M_PI;
            QUAD_4: ref_sum = TWO_PI_RND - a3_r_reg;
            default: ref_sum = a3_r_reg + X_RND_Q56;
        endcase
    end

    assign x_next  = ref_sum[SHIFT_X+X_W-1:SHIFT_X];
    assign sq_next = SQ_W'(a4_x_reg) * SQ_W'(a4_x_reg);
    assign sq_sum  = (SQ_W + 1)'(a5_sq_reg) + SQ_RND;

    always_comb begin
        head_ctx_next.func = a5_func_reg;
        head_ctx_next.quad = a5_quad_reg;
        head_ctx_next.x    = a5_x_reg;
        head_ctx_next.x2   = sq_sum[Q_FRAC+X2_W-1:Q_FRAC];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a1_valid_reg   <= 1'b0;
            a2_valid_reg   <= 1'b0;
            a3_valid_reg   <= 1'b0;
            a4_valid_reg   <= 1'b0;
            a5_valid_reg   <= 1'b0;
            head_valid_reg <= 1'b0;
        end else if (en) begin
            a1_valid_reg   <= s_valid;
            a2_valid_reg   <= a1_valid_reg;
            a3_valid_reg   <= a2_valid_reg;
            a4_valid_reg   <= a3_valid_reg;
            a5_valid_reg   <= a4_valid_reg;
            head_valid_reg <= a5_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a1_func_reg  <= s_func;
            a1_v_reg     <= v_next;
            a1_off_reg   <= off_next;
            a2_func_reg  <= a1_func_reg;
            a2_r_reg     <= r_next;
            a3_func_reg  <= a2_func_reg;
            a3_r_reg     <= a2_r_reg;
            a3_quad_reg  <= quad_next;
            a4_func_reg  <= a3_func_reg;
            a4_quad_reg  <= a3_quad_reg;
            a4_x_reg     <= x_next;
            a5_func_reg  <= a4_func_reg;
            a5_quad_reg  <= a4_quad_reg;
            a5_x_reg     <= a4_x_reg;
            a5_sq_reg    <= sq_next;
            head_ctx_reg <= head_ctx_next;
        end
    end

    // ---- Horner steps, highest term first ----
    assign st_valid[0] = head_valid_reg;
    assign st_ctx[0]   = head_ctx_reg;
    assign st_h[0]     = Q30_ONE;

    for (genvar gi = 0; gi < TERMS - 1; gi++) begin : g_step
        localparam int K  = TERMS - 1 - gi;
        localparam int DS = 2 * K * (2 * K + 1);
        localparam int DC = (2 * K - 1) * (2 * K);
        localparam logic [63:0] MS = 64'h1_0000_0000 / 64'(DS);
        localparam logic [63:0] MC = 64'h1_0000_0000 / 64'(DC);

        tsc_coef_t coef;

        assign coef.d_sin = D_W'(DS);
        assign coef.d_cos = D_W'(DC);
        assign coef.m_sin = MS[M_W-1:0];
        assign coef.m_cos = MC[M_W-1:0];

        tsc_horner_step u_step (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .coef      (coef),
            .in_valid  (st_valid[gi]),
            .in_ctx    (st_ctx[gi]),
            .in_h      (st_h[gi]),
            .out_valid (st_valid[gi+1]),
            .out_ctx   (st_ctx[gi+1]),
            .out_h     (st_h[gi+1])
        );
    end

    // ---- finish: sine multiply, sign, clamp ----
    // sine keeps a positive h; the product is unused for cosine
    assign fin1_prod_next = FP_W'(st_ctx[TERMS-1].x) * FP_W'(st_h[TERMS-1][H_W-2:0]);
    assign fp_sum         = (FP_W + 1)'(fin1_prod_reg) + FP_RND;

    always_comb begin
        if (fin1_ctx_reg.func == FUNC_COS) begin
            mag_next = {fin1_h_reg[H_W-1], fin1_h_reg};
            neg_next = (fin1_ctx_reg.quad == QUAD_2) || (fin1_ctx_reg.quad == QUAD_3);
        end else begin
            mag_next = {1'b0, fp_sum[Q_FRAC+VALUE_W-1:Q_FRAC]};
            neg_next = (fin1_ctx_reg.quad == QUAD_3) || (fin1_ctx_reg.quad == QUAD_4);
        end
    end

    always_comb begin
        priority if (fin2_mag_reg > ONE_MAG) begin
            clamp_mag = ONE_MAG;
        end else if (fin2_mag_reg < NEG_ONE_MAG) begin
            clamp_mag = NEG_ONE_MAG;
        end else begin
            clamp_mag = fin2_mag_reg;
        end
    end

    assign signed_mag = fin2_neg_reg ? -clamp_mag : clamp_mag;
    assign res_value  = signed_mag[VALUE_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fin1_valid_reg <= 1'b0;
            fin2_valid_reg <= 1'b0;
        end else if (en) begin
            fin1_valid_reg <= st_valid[TERMS-1];
            fin2_valid_reg <= fin1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            fin1_ctx_reg  <= st_ctx[TERMS-1];
            fin1_h_reg    <= st_h[TERMS-1];
            fin1_prod_reg <= fin1_prod_next;
            fin2_mag_reg  <= mag_next;
            fin2_neg_reg  <= neg_next;
        end
    end

    // ---- two-word output buffer ----
    always_comb begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_value_next  = out_value_reg;
        skid_value_next = skid_value_reg;
        out_take        = out_valid_reg && m_ready;
        if (skid_valid_reg) begin
            if (out_take) begin
                out_value_next  = skid_value_reg;
                skid_valid_next = 1'b0;
            end
        end else if (fin2_valid_reg) begin
            if (!out_valid_reg || out_take) begin
                out_valid_next = 1'b1;
                out_value_next = res_value;
            end else begin
                skid_valid_next = 1'b1;
                skid_value_next = res_value;
            end
        end else if (out_take) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_value_reg  <= out_value_next;
        skid_value_reg <= skid_value_next;
    end

    assign m_valid = out_valid_reg;
    assign m_value = out_value_reg;

endmodule

>>> bench/taylor_sine_cosine_checker.sv
// Checker for taylor_sine_cosine: watches both channels, predicts each value and compares.
module taylor_sine_cosine_checker
    import tsc_pkg::*;
#(
    parameter int TERMS = TERMS_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    input  logic                      s_ready,
    input  logic                      s_func,
    input  logic signed [ANGLE_W-1:0] s_angle,
    input  logic                      m_valid,
    input  logic                      m_ready,
    input  logic signed [VALUE_W-1:0] m_value,
    output int                        mismatches,
    output int                        pending,
    output int                        checked
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic                      func;
        logic signed [ANGLE_W-1:0] angle;
        logic signed [VALUE_W-1:0] value;
    } trig_word_t;

    trig_word_t expected_values[$];
    trig_word_t oldest;

    // round to nearest, ties away from zero; den > 0
    function automatic longint div_nearest(longint num, longint den);
        if (num >= 0) begin
            return (num + den / 2) / den;
        end
        return -((-num + den / 2) / den);
    endfunction

    function automatic logic signed [VALUE_W-1:0] taylor_value(
        logic func, logic signed [ANGLE_W-1:0] angle);
        longint two_pi, pi_q, half_pi, three_half_pi, one;
        longint r, fold, x, x2, h, d, res;
        quad_t quad;
        int k;
        two_pi        = longint'(TWO_PI_Q56);
        pi_q          = longint'(PI_Q56);
        half_pi       = longint'(HALF_PI_Q56);
        three_half_pi = longint'(THREE_HALF_PI_Q56);
        one           = longint'(Q30_ONE);

        r = (longint'(angle) * 64'sd268435456) % two_pi;
        if (r < 0) begin
            r = r + two_pi;
        end

        if (r <= half_pi) begin
            quad = QUAD_1;
            fold = r;
        end else if (r <= pi_q) begin
            quad = QUAD_2;
            fold = pi_q - r;
        end else if (r <= three_half_pi) begin
            quad = QUAD_3;
            fold = r - pi_q;
        end else begin
            quad = QUAD_4;
            fold = two_pi - r;
        end

        // Q.56 -> Q.30, ties up
        x  = (fold + 64'sd33554432) >>> 26;
        x2 = (x * x + 64'sd536870912) >>> 30;

        h = one;
        for (k = TERMS - 1; k >= 1; k--) begin
            if (func == FUNC_COS) begin
                d = longint'(2 * k - 1) * longint'(2 * k);
            end else begin
                d = longint'(2 * k) * longint'(2 * k + 1);
            end
            h = one - div_nearest(x2 * h, d * one);
        end

        if (func == FUNC_COS) begin
            res = h;
            if (quad == QUAD_2 || quad == QUAD_3) begin
                res = -res;
            end
        end else begin
            res = div_nearest(x * h, one);
            if (quad == QUAD_3 || quad == QUAD_4) begin
                res = -res;
            end
        end

        if (res > one) begin
            res = one;
        end
        if (res < -one) begin
            res = -one;
        end
        return res[VALUE_W-1:0];
    endfunction

    task automatic report_mismatch(input string what);
        if (mismatches < 50) begin
            $display("%0t ns mismatch: %s", $time, what);
        end
        mismatches++;
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            expected_values.delete();
            mismatches = 0;
            pending    = 0;
            checked    = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_values.size() == 0) begin
                    report_mismatch($sformatf("value %h with no word outstanding", m_value));
                end else begin
                    oldest = expected_values.pop_front();
                    if (m_value !== oldest.value) begin
                        report_mismatch($sformatf("func %0d angle %h: value %h, expected %h",
                            oldest.func, oldest.angle, m_value, oldest.value));
                    end
                    checked++;
                end
            end
            if (s_valid && s_ready) begin
                expected_values.push_back('{func: s_func, angle: s_angle,
                                            value: taylor_value(s_func, s_angle)});
            end
            pending = expected_values.size();
        end
    end

endmodule

>>> bench/taylor_sine_cosine_tb.sv
// Testbench top for taylor_sine_cosine: clock, reset, angle stimulus, sink stalls and verdict.
module taylor_sine_cosine_tb
    import tsc_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TERMS_TB    = TERMS_DEF;
    localparam int N_RANDOM    = 526;
    localparam int QUARTER_Q28 = 421657428;   // pi/2 in Q4.28

    logic                      aclk = 1'b0;
    logic                      aresetn;
    logic                      s_valid;
    logic                      s_ready;
    logic                      s_func;
    logic signed [ANGLE_W-1:0] s_angle;
    logic                      m_valid;
    logic                      m_ready;
    logic signed [VALUE_W-1:0] m_value;

    int mismatches;
    int pending;
    int checked;
    int gap_pct    = 0;
    int stall_pct  = 0;
    int stall_left = 0;
    int n_sin      = 0;
    int n_cos      = 0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    taylor_sine_cosine #(
        .TERMS(TERMS_TB)
    ) dut (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_func (s_func),
        .s_angle(s_angle),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_value(m_value)
    );

    taylor_sine_cosine_checker #(
        .TERMS(TERMS_TB)
    ) checker_i (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_func    (s_func),
        .s_angle   (s_angle),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_value   (m_value),
        .mismatches(mismatches),
        .pending   (pending),
        .checked   (checked)
    );

    // sink: random stall bursts on m_ready
    initial begin
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
                stall_left = $urandom_range(0, 6);
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    task automatic send_word(input logic func, input logic signed [ANGLE_W-1:0] angle);
        if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_func  <= func;
        s_angle <= angle;
        if (func == FUNC_COS) begin
            n_cos++;
        end else begin
            n_sin++;
        end
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
    endtask

    initial begin
        logic signed [ANGLE_W-1:0] corner [12];
        logic signed [ANGLE_W-1:0] a;
        logic                      f;
        int i;
        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_func  <= FUNC_SIN;
        s_angle <= '0;
        corner = '{32'sh00000000, 32'sh00000001, 32'shFFFFFFFF, 32'sh7FFFFFFF,
                   32'sh80000000, 32'sh1921FB54, 32'sh3243F6A8, 32'sh3243F6A9,
                   32'sh4B65F1FD, 32'sh6487ED51, -32'sh1921FB54, 32'sh10000000};
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // zero, extremes, quadrant boundaries, negative angles; both functions
        for (i = 0; i < 12; i++) begin
            send_word(FUNC_SIN, corner[i]);
            send_word(FUNC_COS, corner[i]);
        end

        for (i = 0; i < N_RANDOM; i++) begin
            if (i < 130) begin
                gap_pct   = 0;
                stall_pct = 0;
            end else if (i < 260) begin
                gap_pct   = 25;
                stall_pct = 25;
            end else if (i < 390) begin
                gap_pct   = 60;
                stall_pct = 60;
            end else begin
                gap_pct   = 0;
                stall_pct = 0;
            end
            f = 1'($urandom_range(0, 1));
            case ($urandom_range(0, 3))
                0, 1: a = $urandom;
                2: a = (int'($urandom_range(0, 10)) - 5) * QUARTER_Q28
                       + int'($urandom_range(0, 64)) - 32;
                default: begin
                    a = $urandom & (32'hFFFFFFFF >> $urandom_range(0, 31));
                    if ($urandom_range(0, 1) == 1) begin
                        a = -a;
                    end
                end
            endcase
            send_word(f, a);
        end
        s_valid <= 1'b0;

        @(posedge aclk);
        while (pending != 0) begin
            @(posedge aclk);
        end
        repeat (60) @(posedge aclk);

        $display("sent %0d angle words (%0d sine, %0d cosine) with corners and random angles,",
            n_sin + n_cos, n_sin, n_cos);
        $display("under phases of source gaps and sink stalls; %0d values compared",
            checked);
        if (mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    initial begin
        #1_000_000;
        $display("timeout with %0d values outstanding", pending);
        $display("status: fail");
        $finish;
    end

endmodule

>>> sim.f
rtl/tsc_pkg.sv
rtl/tsc_horner_step.sv
rtl/taylor_sine_cosine.sv
bench/taylor_sine_cosine_checker.sv
bench/taylor_sine_cosine_tb.sv
